// ===== rtl/core/assert_macros.svh =====
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== rtl/core/sntf_pkg.sv =====
package sntf_pkg;

	localparam int DEF_MAX_DEGREES = 32;
	localparam logic [31:0] PERIOD_OCTAVE = 32'h8000_0000;
	localparam int RECIP12 = 171;
	localparam int RECIP12_SHIFT = 11;
	localparam int KDIV_STEPS = 7;
	localparam int PDIV_STEPS = 56;
	localparam int CNT_W = 6;

	typedef enum logic [2:0] {
		CFG_SCALE_PERIOD = 3'd0,
		CFG_DEGREE_COUNT = 3'd1,
		CFG_ROOT_NOTE    = 3'd2,
		CFG_REF_PITCH    = 3'd3,
		CFG_SNAP_TO_KEYS = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic        func;
		logic [4:0]  entry_index;
		logic [31:0] entry_value;
		logic [6:0]  midi_note;
	} item_t;

	typedef struct packed {
		logic [31:0] frequency;
		logic        saturated;
	} result_t;

	typedef struct packed {
		logic [31:0] scale_period;
		logic [5:0]  degree_count;
		logic [6:0]  root_note;
		logic [31:0] ref_pitch;
		logic        snap_to_keys;
	} cfg_t;

	typedef enum logic [4:0] {
		S_IDLE, S_ROOT_MUL, S_ROOT_ACC, S_KDIV_INIT, S_KDIV_STEP, S_KDIV_FIX,
		S_BRANCH, S_MQ_LO, S_MQ_HI, S_MQ_ADD, S_PDIV_INIT, S_PDIV_STEP,
		S_PDIV_END, S_RATIO_RD, S_RATIO_LD, S_SNAP_INIT, S_SNAP_RD, S_SNAP_LD,
		S_SNAP_M1, S_SNAP_M2, S_SNAP_CMP, S_SNAP_SHIFT, S_OUT
	} state_t;

	typedef enum logic [4:0] {
		OP_NONE, OP_LATCH, OP_ROOT_MUL, OP_ROOT_ACC, OP_KDIV_INIT, OP_KDIV_STEP,
		OP_KDIV_FIX, OP_MQ_LO, OP_MQ_HI, OP_MQ_ADD, OP_PDIV_INIT, OP_PDIV_STEP,
		OP_PDIV_END, OP_RATIO_RD, OP_RATIO_LD, OP_SNAP_INIT, OP_SNAP_RD,
		OP_SNAP_LD, OP_SNAP_M1, OP_SNAP_M2, OP_SNAP_CMP, OP_SNAP_SHIFT, OP_EMIT
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} cmd_t;

	typedef struct packed {
		logic snap;
		logic loop_zero;
		logic oct_neg;
		logic sat;
		logic cand_last;
	} status_t;

	// 2^(i/12) in UQ1.31
	function automatic logic [31:0] semi_q31(input logic [3:0] i);
		logic [31:0] v;
		case (i)
			4'd0: v = 32'd2147483648;
			4'd1: v = 32'd2275179671;
			4'd2: v = 32'd2410468894;
			4'd3: v = 32'd2553802834;
			4'd4: v = 32'd2705659852;
			4'd5: v = 32'd2866546760;
			4'd6: v = 32'd3037000500;
			4'd7: v = 32'd3217589947;
			4'd8: v = 32'd3408917803;
			4'd9: v = 32'd3611622603;
			4'd10: v = 32'd3826380858;
			4'd11: v = 32'd4053909305;
			default: v = 32'd0;
		endcase
		return v;
	endfunction

endpackage

// ===== rtl/core/scale_note_to_frequency.sv =====
// Scale note to frequency.
// Input: start with item; taken when start is high and busy is low.
// func 0 writes ratio table entry entry_index (ignored at MAX_DEGREES or above)
// in that cycle, produces no result and leaves busy low.
// func 1 converts midi_note to a frequency in Hz (UQ16.16); busy rises for the
// whole computation and done strobes for one cycle with result valid.
// The work runs on the shared 32x32 multiplier and one-bit-per-cycle dividers:
// a plain conversion multiplies by the period for each octave up or divides
// by it for each octave down, then multiplies by the table ratio; snap tries
// each degree in use and the period as candidates, then multiplies by the best.
// Saturation ends the work early. One conversion at a time.
// Configuration via cfg_we/cfg_index/cfg_data, only while idle.
// Reset: registers return to 2.0 period, 12 degrees, root 69, 440 Hz, snap off;
// the ratio table is not cleared and entries must be written before use.
// The receiver cannot stall: each result beat is shown for exactly one cycle.
module scale_note_to_frequency import sntf_pkg::*; #(
	parameter int MAX_DEGREES = DEF_MAX_DEGREES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        start,
	input  item_t       item,
	output logic        busy,
	output logic        done,
	output result_t     result
);

	localparam int AW = (MAX_DEGREES > 1) ? $clog2(MAX_DEGREES) : 1;

	cfg_t          cfg_q;
	cmd_t          cmd;
	status_t       status;
	logic [AW-1:0] raddr;
	logic [31:0]   rdata;
	logic          ram_we;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.scale_period <= PERIOD_OCTAVE;
			cfg_q.degree_count <= 6'd12;
			cfg_q.root_note    <= 7'd69;
			cfg_q.ref_pitch    <= 32'd461373440;
			cfg_q.snap_to_keys <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SCALE_PERIOD: cfg_q.scale_period <= cfg_data;
				CFG_DEGREE_COUNT: cfg_q.degree_count <= cfg_data[5:0];
				CFG_ROOT_NOTE:    cfg_q.root_note    <= cfg_data[6:0];
				CFG_REF_PITCH:    cfg_q.ref_pitch    <= cfg_data;
				CFG_SNAP_TO_KEYS: cfg_q.snap_to_keys <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	assign ram_we = start && !busy && !item.func
		&& ({2'b00, item.entry_index} < 7'(MAX_DEGREES));

	sntf_ram #(
		.WIDTH(32),
		.DEPTH(MAX_DEGREES)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(AW'(item.entry_index)),
		.wdata(item.entry_value),
		.raddr(raddr),
		.rdata(rdata)
	);

	sntf_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.func  (item.func),
		.status(status),
		.cmd   (cmd),
		.busy  (busy),
		.done  (done)
	);

	sntf_dp #(
		.MAX_DEGREES(MAX_DEGREES)
	) u_dp (
		.clk      (clk),
		.cfg      (cfg_q),
		.midi_note(item.midi_note),
		.cmd      (cmd),
		.status   (status),
		.raddr    (raddr),
		.rdata    (rdata),
		.result   (result)
	);

endmodule

// ===== rtl/core/sntf_ram.sv =====
module sntf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/core/sntf_ctrl.sv =====
module sntf_ctrl import sntf_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  logic    func,
	input  status_t status,
	output cmd_t    cmd,
	output logic    busy,
	output logic    done
);

	state_t state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic final_q, final_d;
	logic done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			final_q <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			final_q <= final_d;
			done_q  <= (state_q == S_OUT);
		end
	end

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		final_d = final_q;
		cmd.op  = OP_NONE;
		case (state_q)
			S_IDLE: begin
				if (start && func) begin
					cmd.op  = OP_LATCH;
					final_d = 1'b0;
					state_d = S_ROOT_MUL;
				end
			end
			S_ROOT_MUL: begin
				cmd.op  = OP_ROOT_MUL;
				state_d = S_ROOT_ACC;
			end
			S_ROOT_ACC: begin
				cmd.op  = OP_ROOT_ACC;
				state_d = status.snap ? S_SNAP_INIT : S_KDIV_INIT;
			end
			S_KDIV_INIT: begin
				cmd.op  = OP_KDIV_INIT;
				cnt_d   = CNT_W'(KDIV_STEPS - 1);
				state_d = S_KDIV_STEP;
			end
			S_KDIV_STEP: begin
				cmd.op = OP_KDIV_STEP;
				if (cnt_q == '0) begin
					state_d = S_KDIV_FIX;
				end else begin
					cnt_d = cnt_q - 1'b1;
				end
			end
			S_KDIV_FIX: begin
				cmd.op  = OP_KDIV_FIX;
				state_d = S_BRANCH;
			end
			S_BRANCH: begin
				if (status.sat) begin
					state_d = S_OUT;
				end else if (status.loop_zero) begin
					state_d = S_RATIO_RD;
				end else if (status.oct_neg) begin
					state_d = S_PDIV_INIT;
				end else begin
					state_d = S_MQ_LO;
				end
			end
			S_MQ_LO: begin
				cmd.op  = OP_MQ_LO;
				state_d = S_MQ_HI;
			end
			S_MQ_HI: begin
				cmd.op  = OP_MQ_HI;
				state_d = S_MQ_ADD;
			end
			S_MQ_ADD: begin
				cmd.op  = OP_MQ_ADD;
				state_d = final_q ? S_OUT : S_BRANCH;
			end
			S_PDIV_INIT: begin
				cmd.op  = OP_PDIV_INIT;
				cnt_d   = CNT_W'(PDIV_STEPS - 1);
				state_d = S_PDIV_STEP;
			end
			S_PDIV_STEP: begin
				cmd.op = OP_PDIV_STEP;
				if (status.sat) begin
					state_d = S_OUT;
				end else if (cnt_q == '0) begin
					state_d = S_PDIV_END;
				end else begin
					cnt_d = cnt_q - 1'b1;
				end
			end
			S_PDIV_END: begin
				cmd.op  = OP_PDIV_END;
				state_d = S_BRANCH;
			end
			S_RATIO_RD: begin
				cmd.op  = OP_RATIO_RD;
				state_d = S_RATIO_LD;
			end
			S_RATIO_LD: begin
				cmd.op  = OP_RATIO_LD;
				final_d = 1'b1;
				state_d = S_MQ_LO;
			end
			S_SNAP_INIT: begin
				cmd.op  = OP_SNAP_INIT;
				state_d = S_SNAP_RD;
			end
			S_SNAP_RD: begin
				cmd.op  = OP_SNAP_RD;
				state_d = S_SNAP_LD;
			end
			S_SNAP_LD: begin
				cmd.op  = OP_SNAP_LD;
				state_d = S_SNAP_M1;
			end
			S_SNAP_M1: begin
				cmd.op  = OP_SNAP_M1;
				state_d = S_SNAP_M2;
			end
			S_SNAP_M2: begin
				cmd.op  = OP_SNAP_M2;
				state_d = S_SNAP_CMP;
			end
			S_SNAP_CMP: begin
				cmd.op  = OP_SNAP_CMP;
				state_d = status.cand_last ? S_SNAP_SHIFT : S_SNAP_RD;
			end
			S_SNAP_SHIFT: begin
				cmd.op  = OP_SNAP_SHIFT;
				final_d = 1'b1;
				state_d = S_MQ_LO;
			end
			S_OUT: begin
				cmd.op  = OP_EMIT;
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

endmodule

// ===== rtl/core/sntf_dp.sv =====
module sntf_dp import sntf_pkg::*; #(
	parameter int MAX_DEGREES = DEF_MAX_DEGREES,
	parameter int NW = $clog2(MAX_DEGREES + 1),
	parameter int AW = (MAX_DEGREES > 1) ? $clog2(MAX_DEGREES) : 1
) (
	input  logic          clk,
	input  cfg_t          cfg,
	input  logic [6:0]    midi_note,
	input  cmd_t          cmd,
	output status_t       status,
	output logic [AW-1:0] raddr,
	input  logic [31:0]   rdata,
	output result_t       result
);

	localparam logic [55:0] CLAMP = '1;

	logic [6:0]    note_q;
	logic [55:0]   acc_q;
	logic          sat_q;
	logic [63:0]   prod_q, prodh_q;
	logic [31:0]   opnd_q;
	logic [6:0]    kmag_q, kq_q;
	logic [NW-1:0] krem_q;
	logic          kneg_q;
	logic [7:0]    loop_q;
	logic          oct_neg_q;
	logic [AW-1:0] idx_q;
	logic [31:0]   prem_q;
	logic [55:0]   pdsh_q, pquot_q;
	logic [31:0]   target_q;
	logic [4:0]    sq_q;
	logic [NW-1:0] i_q;
	logic [31:0]   cand_q, big_q, small_q, best_q, bbig_q, bsm_q;
	logic          have_q;
	result_t       result_q;

	logic [NW-1:0] n;
	logic [7:0]    ru;
	logic [15:0]   rprod;
	logic [3:0]    rq, res_i;
	logic [4:0]    rsh;
	logic [8:0]    su;
	logic [17:0]   sprod;
	logic [4:0]    sq;
	logic [3:0]    ssemi;
	logic [32:0]   tgt;
	logic [31:0]   ma, mb;
	logic [63:0]   mul_p;
	logic [NW:0]   kt;
	logic          kge;
	logic [32:0]   pt;
	logic          pge;
	logic [58:0]   mq_sum;
	logic [65:0]   lsh;
	logic [31:0]   cand_c;

	always_comb begin
		if (cfg.degree_count == '0) begin
			n = NW'(1);
		end else if ({1'b0, cfg.degree_count} > 7'(MAX_DEGREES)) begin
			n = NW'(MAX_DEGREES);
		end else begin
			n = NW'(cfg.degree_count);
		end
	end

	// floor division by twelve through a reciprocal
	assign ru    = {1'b0, cfg.root_note} + 8'd3;
	assign rprod = 16'(ru) * 16'(RECIP12);
	assign rq    = 4'(rprod >> RECIP12_SHIFT);
	assign res_i = 4'(ru - 8'(rq) * 8'd12);
	assign rsh   = 5'd25 - 5'(rq);

	assign su    = 9'(note_q) + 9'd132 - 9'(cfg.root_note);
	assign sprod = 18'(su) * 18'(RECIP12);
	assign sq    = 5'(sprod >> RECIP12_SHIFT);
	assign ssemi = 4'(su - 9'(sq) * 9'd12);
	assign tgt   = ({1'b0, semi_q31(ssemi)} + 33'd1) >> 1;

	always_comb begin
		ma = '0;
		mb = '0;
		case (cmd.op)
			OP_ROOT_MUL: begin
				ma = cfg.ref_pitch;
				mb = semi_q31(res_i);
			end
			OP_MQ_LO: begin
				ma = acc_q[31:0];
				mb = opnd_q;
			end
			OP_MQ_HI: begin
				ma = {8'd0, acc_q[55:32]};
				mb = opnd_q;
			end
			OP_SNAP_M1: begin
				ma = big_q;
				mb = bsm_q;
			end
			OP_SNAP_M2: begin
				ma = bbig_q;
				mb = small_q;
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
	end

	assign mul_p  = 64'(ma) * 64'(mb);
	assign kt     = {krem_q, kmag_q[6]};
	assign kge    = kt >= {1'b0, n};
	assign pt     = {prem_q, pdsh_q[55]};
	assign pge    = pt >= {1'b0, cfg.scale_period};
	assign mq_sum = {1'b0, prodh_q[55:0], 2'b00} + 59'(prod_q[63:30]);
	assign lsh    = {10'd0, acc_q} << (sq_q - 5'd11);
	assign cand_c = (i_q == n) ? cfg.scale_period : rdata;

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LATCH: begin
				note_q <= midi_note;
			end
			OP_ROOT_MUL: begin
				prod_q <= mul_p;
			end
			OP_ROOT_ACC: begin
				acc_q <= 56'(prod_q >> rsh);
				sat_q <= 1'b0;
			end
			OP_KDIV_INIT: begin
				kneg_q <= note_q < cfg.root_note;
				kmag_q <= (note_q < cfg.root_note) ? cfg.root_note - note_q
					: note_q - cfg.root_note;
				krem_q <= '0;
				kq_q   <= '0;
			end
			OP_KDIV_STEP: begin
				krem_q <= kge ? NW'(kt - {1'b0, n}) : NW'(kt);
				kq_q   <= {kq_q[5:0], kge};
				kmag_q <= {kmag_q[5:0], 1'b0};
			end
			OP_KDIV_FIX: begin
				oct_neg_q <= kneg_q;
				opnd_q    <= cfg.scale_period;
				if (kneg_q && krem_q != '0) begin
					loop_q <= {1'b0, kq_q} + 8'd1;
					idx_q  <= AW'(n - krem_q);
				end else begin
					loop_q <= {1'b0, kq_q};
					idx_q  <= AW'(krem_q);
				end
			end
			OP_MQ_LO: begin
				prod_q <= mul_p;
			end
			OP_MQ_HI: begin
				prodh_q <= mul_p;
			end
			OP_MQ_ADD: begin
				if (sat_q || mq_sum[58:56] != '0) begin
					sat_q <= 1'b1;
					acc_q <= CLAMP;
				end else begin
					acc_q <= mq_sum[55:0];
				end
				if (loop_q != '0) begin
					loop_q <= loop_q - 8'd1;
				end
			end
			OP_PDIV_INIT: begin
				if (cfg.scale_period == '0 || {2'b00, acc_q[55:26]} >= cfg.scale_period) begin
					sat_q <= 1'b1;
					acc_q <= CLAMP;
				end
				prem_q  <= {2'b00, acc_q[55:26]};
				pdsh_q  <= {acc_q[25:0], 30'd0};
				pquot_q <= '0;
			end
			OP_PDIV_STEP: begin
				prem_q  <= pge ? 32'(pt - {1'b0, cfg.scale_period}) : 32'(pt);
				pquot_q <= {pquot_q[54:0], pge};
				pdsh_q  <= {pdsh_q[54:0], 1'b0};
			end
			OP_PDIV_END: begin
				acc_q  <= pquot_q;
				loop_q <= loop_q - 8'd1;
			end
			OP_RATIO_LD: begin
				opnd_q <= rdata;
			end
			OP_SNAP_INIT: begin
				target_q <= tgt[31:0];
				sq_q     <= sq;
				i_q      <= '0;
				have_q   <= 1'b0;
				bbig_q   <= 32'd1;
				bsm_q    <= '0;
			end
			OP_SNAP_LD: begin
				cand_q  <= cand_c;
				big_q   <= (cand_c > target_q) ? cand_c : target_q;
				small_q <= (cand_c > target_q) ? target_q : cand_c;
			end
			OP_SNAP_M1: begin
				prod_q <= mul_p;
			end
			OP_SNAP_M2: begin
				prodh_q <= mul_p;
			end
			OP_SNAP_CMP: begin
				if (cand_q != '0 && (!have_q || prod_q < prodh_q)) begin
					have_q <= 1'b1;
					best_q <= cand_q;
					bbig_q <= big_q;
					bsm_q  <= small_q;
				end
				i_q <= i_q + 1'b1;
			end
			OP_SNAP_SHIFT: begin
				opnd_q <= best_q;
				if (sq_q >= 5'd11) begin
					if (lsh[65:56] != '0) begin
						sat_q <= 1'b1;
						acc_q <= CLAMP;
					end else begin
						acc_q <= lsh[55:0];
					end
				end else begin
					acc_q <= acc_q >> (5'd11 - sq_q);
				end
			end
			OP_EMIT: begin
				if (sat_q || acc_q[55:48] != '0) begin
					result_q.frequency <= '1;
					result_q.saturated <= 1'b1;
				end else begin
					result_q.frequency <= acc_q[47:16];
					result_q.saturated <= 1'b0;
				end
			end
			default: begin
			end
		endcase
	end

	assign raddr            = (cmd.op == OP_SNAP_RD) ? AW'(i_q) : idx_q;
	assign status.snap      = cfg.snap_to_keys && (cfg.scale_period == PERIOD_OCTAVE);
	assign status.loop_zero = (loop_q == '0);
	assign status.oct_neg   = oct_neg_q;
	assign status.sat       = sat_q;
	assign status.cand_last = (i_q == n);
	assign result           = result_q;

endmodule

// ===== rtl/core/sntf_checker.sv =====
`include "assert_macros.svh"

module sntf_checker import sntf_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    start,
	input item_t   item,
	input logic    busy,
	input logic    done,
	input result_t result
);

	`ASSERT_NOW(a_done_after_busy, clk, arst_n, done, $past(busy))
	`ASSERT_NEXT(a_note_goes_busy, clk, arst_n, start && !busy && item.func, busy)
	`ASSERT_NEXT(a_write_no_beat, clk, arst_n, start && !busy && !item.func, !busy && !done)
	`ASSERT_NEXT(a_single_beat, clk, arst_n, done, !done)
	`ASSERT_NOW(a_sat_all_ones, clk, arst_n, done && result.saturated, result.frequency == '1)

endmodule

bind scale_note_to_frequency sntf_checker u_chk (.*);
